### src/height_to_normal_map_assert.svh
// ----------------------------------------------------------------------------
// height_to_normal_map_assert.svh
// Assertion macros of the height-to-normal-map RTL, used by htnm_norm.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TO_NORMAL_MAP_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define HTNM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htnm assertion failed");

// Next-cycle implication, disabled while in reset
`define HTNM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htnm assertion failed");

`endif

### src/htnm_pkg.sv
// ----------------------------------------------------------------------------
// htnm_pkg
// Types, codes and constants of the height-to-normal-map block.
// ----------------------------------------------------------------------------
package htnm_pkg;

  // Sizes
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int SAMPLE_BITS    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [WIDTH_W-1:0]   WIDTH_RESET      = 11'd256;
  localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET     = 13'd512;

  // Input kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  // Output field widths
  localparam int COL_OUT_W = 10;
  localparam int ROW_OUT_W = 12;

  // Arithmetic
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int Q_W    = PROD_W;
  localparam int CMP_W  = 50;
  localparam logic [MUL_W-1:0] K_65025 = 17'd65025;
  // z-term of the quarter norm: (2^SAMPLE_BITS)^2 / 4
  localparam logic [Q_W-1:0]   Q_BIAS  = 34'(64'd1 << (2 * SAMPLE_BITS - 2));
  localparam logic [CMP_W-1:0] RHS_Z   = 50'(64'd65025 << (2 * SAMPLE_BITS - 2));

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_WR, ST_BUSY, ST_PUT
  } htnm_state_t;

  // Normalizer sequencer
  typedef enum logic [3:0] {
    N_IDLE, N_SQX, N_SQY, N_R0, N_R1, N_T, N_P0, N_P1, N_CMP, N_FIN
  } htnm_nstate_t;

  // Gradient handed to the normalizer
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] dx_mag;
    logic                   dx_neg;
    logic [SAMPLE_BITS-1:0] dy_mag;
    logic                   dy_neg;
  } htnm_req_t;

  // Bytes returned by the normalizer
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } htnm_res_t;

endpackage

### src/htnm_if.sv
// ----------------------------------------------------------------------------
// htnm_if
// Valid/ready channels of the height-to-normal-map block.
// ----------------------------------------------------------------------------
interface htnm_in_if import htnm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SAMPLE_BITS-1:0] height_sample;
  modport source (output valid, kind, height_sample, input ready);
  modport sink   (input valid, kind, height_sample, output ready);
endinterface

interface htnm_out_if import htnm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [7:0]           normal_red;
  logic [7:0]           normal_green;
  logic [7:0]           normal_blue;
  logic [COL_OUT_W-1:0] pixel_column;
  logic [ROW_OUT_W-1:0] pixel_row;
  logic                 frame_done;
  modport source (output valid, normal_red, normal_green, normal_blue,
                  pixel_column, pixel_row, frame_done, input ready);
  modport sink   (input valid, normal_red, normal_green, normal_blue,
                  pixel_column, pixel_row, frame_done, output ready);
endinterface

interface htnm_cfg_if import htnm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/htnm_ram.sv
// ----------------------------------------------------------------------------
// htnm_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/htnm_norm.sv
// ----------------------------------------------------------------------------
// htnm_norm
// Sequenced normalizer: exact byte of each normal component by binary
// search, using one shared 17x17 multiplier.
// ----------------------------------------------------------------------------
`include "height_to_normal_map_assert.svh"

module htnm_norm import htnm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  htnm_req_t req,
  output logic      done,
  output htnm_res_t res
);

  htnm_nstate_t state_r, state_nxt;
  htnm_req_t    req_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [Q_W-1:0]    q_r;
  logic [PROD_W-1:0] acc_r;
  logic [CMP_W-1:0]  lhs_r, rhs_r;
  logic [15:0]       tt_r;
  logic [7:0]        m_r, lo_r, hi_r;
  logic [1:0]        k_r;
  logic [7:0]        red_r, green_r, blue_r;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [SQ_W-1:0]   sq_sel;
  logic [8:0]        sum9;
  logic [7:0]        m_w, tabs;
  logic              apos, azero, tneg, win;
  logic [7:0]        nlo, nhi;

  // Midpoint of the search and |2m-255|
  assign sum9   = {1'b0, lo_r} + {1'b0, hi_r} + 9'd1;
  assign m_w    = sum9[8:1];
  assign tabs   = {(m_w[7] ? m_w[6:0] : ~m_w[6:0]), 1'b1};
  assign sq_sel = (k_r == 2'd0) ? sqx_r : sqy_r;
  assign prod   = mul_a * mul_b;

  // Sign of the component under search
  always_comb begin
    case (k_r)
      2'd0:    begin apos = req_r.dx_neg; azero = (req_r.dx_mag == '0); end
      2'd1:    begin apos = req_r.dy_neg; azero = (req_r.dy_mag == '0); end
      default: begin apos = 1'b1;         azero = 1'b0;                 end
    endcase
  end

  // Decide one search step: is t*|n| <= 255*a
  assign tneg = ~m_r[7];
  assign win  = tneg ? (apos | azero | (lhs_r >= rhs_r)) : (apos & (lhs_r <= rhs_r));
  assign nlo  = win ? m_r : lo_r;
  assign nhi  = win ? hi_r : m_r - 8'd1;

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      N_SQX: begin mul_a = MUL_W'(req_r.dx_mag); mul_b = MUL_W'(req_r.dx_mag); end
      N_SQY: begin mul_a = MUL_W'(req_r.dy_mag); mul_b = MUL_W'(req_r.dy_mag); end
      N_R0:  begin mul_a = K_65025; mul_b = sq_sel[MUL_W-1:0]; end
      N_R1:  begin mul_a = K_65025; mul_b = MUL_W'(sq_sel[SQ_W-1:MUL_W]); end
      N_T:   begin mul_a = MUL_W'(tabs); mul_b = MUL_W'(tabs); end
      N_P0:  begin mul_a = MUL_W'(tt_r); mul_b = q_r[MUL_W-1:0]; end
      N_P1:  begin mul_a = MUL_W'(tt_r); mul_b = q_r[Q_W-1:MUL_W]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE: if (start) state_nxt = N_SQX;
      N_SQX:  state_nxt = N_SQY;
      N_SQY:  state_nxt = N_R0;
      N_R0:   state_nxt = N_R1;
      N_R1:   state_nxt = N_T;
      N_T:    state_nxt = N_P0;
      N_P0:   state_nxt = N_P1;
      N_P1:   state_nxt = N_CMP;
      N_CMP: begin
        if (nlo == nhi) state_nxt = (k_r == 2'd2) ? N_FIN : N_R0;
        else            state_nxt = N_T;
      end
      N_FIN:  state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      k_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == N_SQY) begin
        k_r <= 2'd0;
      end else if (state_r == N_CMP && nlo == nhi) begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: if (start) req_r <= req;
      N_SQX:  sqx_r <= prod[SQ_W-1:0];
      N_SQY: begin
        sqy_r <= prod[SQ_W-1:0];
        q_r   <= Q_W'(sqx_r) + prod + Q_BIAS;
      end
      N_R0:   acc_r <= prod;
      N_R1: begin
        rhs_r <= (k_r == 2'd2) ? RHS_Z : CMP_W'(acc_r) + (CMP_W'(prod) << MUL_W);
        lo_r  <= 8'd0;
        hi_r  <= 8'd255;
      end
      N_T: begin
        tt_r <= prod[15:0];
        m_r  <= m_w;
      end
      N_P0:   acc_r <= prod;
      N_P1:   lhs_r <= CMP_W'(acc_r) + (CMP_W'(prod) << MUL_W);
      N_CMP: begin
        lo_r <= nlo;
        hi_r <= nhi;
        if (nlo == nhi) begin
          case (k_r)
            2'd0:    red_r   <= nlo;
            2'd1:    green_r <= nlo;
            default: blue_r  <= nlo;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign done      = (state_r == N_FIN);
  assign res.red   = red_r;
  assign res.green = green_r;
  assign res.blue  = blue_r;

  `HTNM_ASSERT_NOW(a_start_idle, clk, rst_n, start, state_r == N_IDLE)
  `HTNM_ASSERT_NOW(a_search_order, clk, rst_n, state_r == N_CMP, lo_r < hi_r && m_r > lo_r)
  `HTNM_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done && state_r == N_IDLE)

endmodule

### src/height_to_normal_map.sv
// ----------------------------------------------------------------------------
// height_to_normal_map
// Streaming height field to normal map converter with two row buffers.
//
//   channel  dir  fields
//   in_ch    in   kind, height_sample
//   out_ch   out  normal_red/green/blue, pixel_column, pixel_row, frame_done
//   cfg_ch   in   index (0 image_width, 1 image_height), data
//
// A request that yields a pixel passes, from accept to the next accept, the
// accept, three row buffer reads, the write, the normalizer (squaring the
// gradient; per component the bound and 8 search steps on the shared 17x17
// multiplier; a finish step), and the load of the output register. A
// first-row sample passes only the accept, reads and write, and a dropped
// request only the accept. Reset is synchronous active low; the row buffers
// need no clearing. A stalled output holds its pixel, and the next request
// is taken while it waits.
// ----------------------------------------------------------------------------
module height_to_normal_map import htnm_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  htnm_in_if.sink     in_ch,
  htnm_out_if.source  out_ch,
  htnm_cfg_if.sink    cfg_ch
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  htnm_state_t state_r, state_nxt;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CW-1:0] in_col_r, drain_col_r, c_r, wm1, cm1, cp1, c_acc;
  logic [RW-1:0] in_row_r, r_r, hm1, r_acc;
  logic          draining_r, drain_r;
  logic [SAMPLE_BITS-1:0] samp_r, old_r, mid_r, lold_r, lnew_r;
  logic [COL_OUT_W-1:0] pcol_r;
  logic [ROW_OUT_W-1:0] prow_r;
  logic                 pdone_r;
  logic                 out_v_r;
  logic [7:0]           ored_r, ogreen_r, oblue_r;

  logic                   accept, go, emit, load;
  logic [CW-1:0]          o_raddr, n_raddr;
  logic                   we;
  logic [SAMPLE_BITS-1:0] o_rdata, n_rdata;
  logic [SAMPLE_BITS-1:0] left, right, up, down;
  logic [SAMPLE_BITS:0]   dx, dy;
  htnm_req_t              req;
  htnm_res_t              res;
  logic                   start, ndone;

  // Used sizes minus one
  always_comb begin
    if (width_r == '0)                    wm1 = '0;
    else if (32'(width_r) > MAX_WIDTH)    wm1 = CW'(MAX_WIDTH - 1);
    else                                  wm1 = CW'(width_r - 11'd1);
    if (height_r == '0)                   hm1 = '0;
    else if (32'(height_r) > MAX_HEIGHT)  hm1 = RW'(MAX_HEIGHT - 1);
    else                                  hm1 = RW'(height_r - 13'd1);
  end

  // Configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_ch.data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_ch.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request acceptance; drop what does not apply
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept = in_ch.valid & in_ch.ready;
  assign go     = accept & ((in_ch.kind == KIND_DRAIN) ? draining_r : !draining_r);
  assign c_acc  = (in_ch.kind == KIND_DRAIN) ? ((drain_col_r > wm1) ? wm1 : drain_col_r)
                                             : ((in_col_r > wm1) ? wm1 : in_col_r);
  assign r_acc  = (in_row_r > hm1) ? hm1 : in_row_r;
  assign cm1    = (c_r == '0) ? c_r : c_r - CW'(1);
  assign cp1    = (c_r == wm1) ? c_r : c_r + CW'(1);

  // Neighbor selection and differences
  always_comb begin
    right = (c_r == wm1) ? mid_r : n_rdata;
    if (c_r == '0) left = mid_r;
    else           left = drain_r ? lnew_r : lold_r;
    if (drain_r) begin
      up   = (hm1 == '0) ? mid_r : old_r;
      down = mid_r;
    end else begin
      up   = (r_r == RW'(1)) ? mid_r : old_r;
      down = samp_r;
    end
    dx = {1'b0, right} - {1'b0, left};
    dy = {1'b0, down} - {1'b0, up};
    req.dx_neg = dx[SAMPLE_BITS];
    req.dx_mag = SAMPLE_BITS'(dx[SAMPLE_BITS] ? ((SAMPLE_BITS + 1)'(0) - dx) : dx);
    req.dy_neg = dy[SAMPLE_BITS];
    req.dy_mag = SAMPLE_BITS'(dy[SAMPLE_BITS] ? ((SAMPLE_BITS + 1)'(0) - dy) : dy);
  end

  assign emit  = drain_r | (r_r != '0);
  assign start = (state_r == ST_WR) & emit;
  assign load  = (state_r == ST_PUT) & (!out_v_r | out_ch.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (go) state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_WR;
      ST_WR:   state_nxt = emit ? ST_BUSY : ST_IDLE;
      ST_BUSY: if (ndone) state_nxt = ST_PUT;
      ST_PUT:  if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Row buffer ports
  always_comb begin
    o_raddr = c_r;
    n_raddr = c_r;
    we      = 1'b0;
    unique case (state_r)
      ST_RD0:  begin o_raddr = c_r; n_raddr = c_r; end
      ST_RD1:  begin o_raddr = cm1; n_raddr = cm1; end
      ST_RD2:  begin o_raddr = c_r; n_raddr = cp1; end
      ST_WR:   we = !drain_r;
      default: ;
    endcase
  end

  htnm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(we), .waddr(c_r), .wdata(mid_r), .raddr(o_raddr), .rdata(o_rdata)
  );

  htnm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_newer (
    .clk(clk), .we(we), .waddr(c_r), .wdata(samp_r), .raddr(n_raddr), .rdata(n_rdata)
  );

  htnm_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(start), .req(req), .done(ndone), .res(res)
  );

  // Control registers: sequencer, positions, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      drain_col_r <= '0;
      draining_r  <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_WR) begin
        if (drain_r) begin
          if (c_r == wm1) draining_r  <= 1'b0;
          else            drain_col_r <= c_r + CW'(1);
        end else if (c_r == wm1) begin
          in_col_r <= '0;
          if (r_r == hm1) begin
            in_row_r    <= '0;
            draining_r  <= 1'b1;
            drain_col_r <= '0;
          end else begin
            in_row_r <= r_r + RW'(1);
          end
        end else begin
          in_col_r <= c_r + CW'(1);
        end
      end
      if (load)              out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (go) begin
      drain_r <= (in_ch.kind == KIND_DRAIN);
      samp_r  <= in_ch.height_sample;
      c_r     <= c_acc;
      r_r     <= r_acc;
    end
    if (state_r == ST_RD1) begin
      old_r <= o_rdata;
      mid_r <= n_rdata;
    end
    if (state_r == ST_RD2) begin
      lold_r <= o_rdata;
      lnew_r <= n_rdata;
    end
    if (load) begin
      ored_r   <= res.red;
      ogreen_r <= res.green;
      oblue_r  <= res.blue;
      pcol_r   <= COL_OUT_W'(c_r);
      prow_r   <= drain_r ? ROW_OUT_W'(hm1) : ROW_OUT_W'(r_r - RW'(1));
      pdone_r  <= drain_r & (c_r == wm1);
    end
  end

  // Output channel
  assign out_ch.valid        = out_v_r;
  assign out_ch.normal_red   = ored_r;
  assign out_ch.normal_green = ogreen_r;
  assign out_ch.normal_blue  = oblue_r;
  assign out_ch.pixel_column = pcol_r;
  assign out_ch.pixel_row    = prow_r;
  assign out_ch.frame_done   = pdone_r;

endmodule
